// ===== hdl/rne_pkg.sv =====
// ----------------------------------------------------------------------------
// rne_pkg
// Shared types, constants and the microcode program of the Roman numeral
// encoder.
// ----------------------------------------------------------------------------
package rne_pkg;

  localparam int NumW  = 12;
  localparam int CodeW = 7;
  localparam int PcW   = 4;

  localparam logic [NumW-1:0]  MAX_VALUE    = 12'd3999;
  localparam logic [CodeW-1:0] NEWLINE_CODE = 7'd10;

  localparam logic [CodeW-1:0] CH_M = 7'h4D;
  localparam logic [CodeW-1:0] CH_D = 7'h44;
  localparam logic [CodeW-1:0] CH_C = 7'h43;
  localparam logic [CodeW-1:0] CH_L = 7'h4C;
  localparam logic [CodeW-1:0] CH_X = 7'h58;
  localparam logic [CodeW-1:0] CH_V = 7'h56;
  localparam logic [CodeW-1:0] CH_I = 7'h49;
  localparam logic [CodeW-1:0] CH_NONE = 7'd0;

  localparam logic [PcW-1:0] PC_FIRST = 4'd0;
  localparam logic [PcW-1:0] PC_FIN   = 4'd13;

  // one control word per program step
  typedef struct packed {
    logic [NumW-1:0]  weight;
    logic [CodeW-1:0] first;
    logic             pair;
    logic [CodeW-1:0] second;
    logic             fin;
  } ucode_t;

  // one character handed from the sequencer to the output register
  typedef struct packed {
    logic             valid;
    logic [CodeW-1:0] code;
    logic             last;
    logic             err;
  } emit_t;

  function automatic ucode_t ucode_rom(input logic [PcW-1:0] addr);
    ucode_t w;
    w = '{weight: '0, first: CH_NONE, pair: 1'b0, second: CH_NONE, fin: 1'b1};
    unique case (addr)
      4'd0:  w = '{12'd1000, CH_M, 1'b0, CH_NONE, 1'b0};
      4'd1:  w = '{12'd900,  CH_C, 1'b1, CH_M,    1'b0};
      4'd2:  w = '{12'd500,  CH_D, 1'b0, CH_NONE, 1'b0};
      4'd3:  w = '{12'd400,  CH_C, 1'b1, CH_D,    1'b0};
      4'd4:  w = '{12'd100,  CH_C, 1'b0, CH_NONE, 1'b0};
      4'd5:  w = '{12'd90,   CH_X, 1'b1, CH_C,    1'b0};
      4'd6:  w = '{12'd50,   CH_L, 1'b0, CH_NONE, 1'b0};
      4'd7:  w = '{12'd40,   CH_X, 1'b1, CH_L,    1'b0};
      4'd8:  w = '{12'd10,   CH_X, 1'b0, CH_NONE, 1'b0};
      4'd9:  w = '{12'd9,    CH_I, 1'b1, CH_X,    1'b0};
      4'd10: w = '{12'd5,    CH_V, 1'b0, CH_NONE, 1'b0};
      4'd11: w = '{12'd4,    CH_I, 1'b1, CH_V,    1'b0};
      4'd12: w = '{12'd1,    CH_I, 1'b0, CH_NONE, 1'b0};
      default: w = '{12'd0,  CH_NONE, 1'b0, CH_NONE, 1'b1};
    endcase
    return w;
  endfunction

endpackage

// ===== hdl/rne_if.sv =====
// ----------------------------------------------------------------------------
// rne_if
// Handshake channels of the Roman numeral encoder: number in, characters out.
// ----------------------------------------------------------------------------
interface rne_num_if;
  logic        valid;
  logic        ready;
  logic [11:0] number_in;

  modport source (output valid, output number_in, input ready);
  modport sink   (input valid, input number_in, output ready);
endinterface

interface rne_char_if;
  logic       valid;
  logic       ready;
  logic [6:0] char_code;
  logic       last_char;
  logic       range_error;

  modport source (output valid, output char_code, output last_char, output range_error,
                  input ready);
  modport sink   (input valid, input char_code, input last_char, input range_error,
                  output ready);
endinterface

// ===== hdl/roman_numeral_encoder_core.sv =====
// ----------------------------------------------------------------------------
// roman_numeral_encoder_core
// Converts one 12-bit unsigned number into its Roman numeral, one ASCII
// character per output beat, closed by a newline beat marked last.
//
//   channel    dir  payload                              role
//   number_ch  in   number_in[11:0]                      value to convert
//   char_ch    out  char_code[6:0] last_char range_error one character
//
// one program step per cycle when the output is not stalled; a step
// emits one letter or moves on, out of range values go straight to the newline
// input ready is low from accept until the newline beat is registered
// a stalled output holds the sequencer without losing a character
// rst is synchronous and clears the sequencer and the output valid
// ----------------------------------------------------------------------------
module roman_numeral_encoder_core (
  input  logic       clk,
  input  logic       rst,
  rne_num_if.sink    number_ch,
  rne_char_if.source char_ch
);
  import rne_pkg::*;

  logic  busy;
  logic  start;
  logic  advance;
  emit_t emit;
  logic  out_valid;
  logic [CodeW-1:0] out_code;
  logic  out_last;
  logic  out_err;

  assign number_ch.ready = !busy;
  assign start   = number_ch.valid && !busy;
  assign advance = !out_valid || char_ch.ready;

  rne_sequencer u_seq (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .number  (number_ch.number_in),
    .advance (advance),
    .busy    (busy),
    .emit    (emit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit.valid) begin
      out_valid <= 1'b1;
    end else if (char_ch.ready) begin
      out_valid <= 1'b0;
    end
    if (emit.valid) begin
      out_code <= emit.code;
      out_last <= emit.last;
      out_err  <= emit.err;
    end
  end

  assign char_ch.valid       = out_valid;
  assign char_ch.char_code   = out_code;
  assign char_ch.last_char   = out_last;
  assign char_ch.range_error = out_err;

endmodule

// ===== hdl/rne_sequencer.sv =====
// ----------------------------------------------------------------------------
// rne_sequencer
// Microcoded sequencer: steps through the symbol program, compares and
// subtracts the remaining value and emits one character per emitting step.
// ----------------------------------------------------------------------------
module rne_sequencer (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [rne_pkg::NumW-1:0] number,
  input  logic                   advance,
  output logic                   busy,
  output rne_pkg::emit_t         emit
);
  import rne_pkg::*;

  logic [PcW-1:0]  pc, pc_next;
  logic            half, half_next;
  logic            busy_next;
  logic            err, err_next;
  logic [NumW-1:0] rest, rest_next;
  ucode_t          uw;
  logic            ge;

  assign uw = ucode_rom(pc);
  assign ge = (rest >= uw.weight);

  always_comb begin
    pc_next   = pc;
    half_next = half;
    busy_next = busy;
    err_next  = err;
    rest_next = rest;
    emit      = '{valid: 1'b0, code: uw.first, last: 1'b0, err: 1'b0};
    if (start) begin
      busy_next = 1'b1;
      half_next = 1'b0;
      rest_next = number;
      err_next  = (number > MAX_VALUE);
      pc_next   = (number > MAX_VALUE) ? PC_FIN : PC_FIRST;
    end else if (busy && advance) begin
      priority if (half) begin
        emit      = '{valid: 1'b1, code: uw.second, last: 1'b0, err: 1'b0};
        half_next = 1'b0;
      end else if (uw.fin) begin
        emit      = '{valid: 1'b1, code: NEWLINE_CODE, last: 1'b1, err: err};
        busy_next = 1'b0;
      end else if (ge) begin
        emit      = '{valid: 1'b1, code: uw.first, last: 1'b0, err: 1'b0};
        rest_next = rest - uw.weight;
        half_next = uw.pair;
      end else begin
        pc_next = pc + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      half <= 1'b0;
      pc   <= PC_FIRST;
      err  <= 1'b0;
    end else begin
      busy <= busy_next;
      half <= half_next;
      pc   <= pc_next;
      err  <= err_next;
    end
    rest <= rest_next;
  end

endmodule

// ===== hdl/rne_checker.sv =====
// ----------------------------------------------------------------------------
// rne_checker
// Port-level checks of the Roman numeral encoder, bound to the top level.
// ----------------------------------------------------------------------------
module rne_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [6:0] char_code,
  input logic       last_char,
  input logic       range_error
);
  import rne_pkg::*;

  // stalled beat holds its payload
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(char_code) && $stable(last_char)
      && $stable(range_error))
    else $error("stalled output beat changed");

  // range error only rides on the closing newline
  assert property (@(posedge clk) disable iff (rst)
    out_valid && range_error |-> last_char)
    else $error("range error on a letter beat");

  // the last beat is the newline and only it
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last_char == (char_code == NEWLINE_CODE)))
    else $error("newline and last flag disagree");

  // no new number is taken while a letter of the current one is pending
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_char |-> !in_ready)
    else $error("input ready while a numeral is in progress");

endmodule

bind roman_numeral_encoder_core rne_checker u_rne_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (number_ch.ready),
  .out_valid   (char_ch.valid),
  .out_ready   (char_ch.ready),
  .char_code   (char_ch.char_code),
  .last_char   (char_ch.last_char),
  .range_error (char_ch.range_error)
);

// ===== tb/roman_numeral_encoder_core_tb.sv =====
// ----------------------------------------------------------------------------
// roman_numeral_encoder_core_tb
// Feeds numbers to the encoder under varying idle and stall patterns and
// checks every character beat against a local greedy Roman numeral predictor.
// ----------------------------------------------------------------------------
import rne_pkg::*;

class numeral_board;

  typedef struct packed {
    logic [CodeW-1:0] code;
    logic             last;
    logic             err;
  } char_beat_t;

  char_beat_t want_chars[$];
  int unsigned mismatches;

  function new();
    mismatches = 0;
  endfunction

  task report(input string what);
    mismatches++;
    if (mismatches <= 50) $display("MISMATCH @%0t: %s", $time, what);
  endtask

  function int unsigned pending();
    return want_chars.size();
  endfunction

  // greedy split, subtractive pairs emit two letters
  function void spell_numeral(input logic [NumW-1:0] n);
    int unsigned      weight [13] = '{1000, 900, 500, 400, 100, 90, 50, 40, 10, 9, 5, 4, 1};
    logic [CodeW-1:0] lead   [13] = '{CH_M, CH_C, CH_D, CH_C, CH_C, CH_X, CH_L,
                                      CH_X, CH_X, CH_I, CH_V, CH_I, CH_I};
    logic [CodeW-1:0] tail   [13] = '{CH_NONE, CH_M, CH_NONE, CH_D, CH_NONE, CH_C,
                                      CH_NONE, CH_L, CH_NONE, CH_X, CH_NONE, CH_V,
                                      CH_NONE};
    int unsigned      rest;
    int unsigned      letters;
    rest    = n;
    letters = 0;
    if (n > MAX_VALUE) begin
      want_chars.push_back('{NEWLINE_CODE, 1'b1, 1'b1});
      return;
    end
    for (int s = 0; s < 13; s++) begin
      while (rest >= weight[s] && letters < 15) begin
        rest -= weight[s];
        want_chars.push_back('{lead[s], 1'b0, 1'b0});
        letters++;
        if (tail[s] != CH_NONE && letters < 15) begin
          want_chars.push_back('{tail[s], 1'b0, 1'b0});
          letters++;
        end
      end
    end
    want_chars.push_back('{NEWLINE_CODE, 1'b1, 1'b0});
  endfunction

  function void note_number(input logic [NumW-1:0] n);
    spell_numeral(n);
  endfunction

  task check_char(input logic [CodeW-1:0] code, input logic last, input logic err);
    char_beat_t w;
    if (want_chars.size() == 0) begin
      report($sformatf("unexpected beat code=%0d last=%0b err=%0b", code, last, err));
      return;
    end
    w = want_chars.pop_front();
    if (code !== w.code)
      report($sformatf("char_code got %0d want %0d", code, w.code));
    if (last !== w.last)
      report($sformatf("last_char got %0b want %0b", last, w.last));
    if (err !== w.err)
      report($sformatf("range_error got %0b want %0b", err, w.err));
  endtask

endclass

module roman_numeral_encoder_core_tb;

  logic clk;
  logic rst;
  int unsigned idle_pct;
  int unsigned stall_pct;
  numeral_board board;

  rne_num_if  num_ch ();
  rne_char_if chr_ch ();

  roman_numeral_encoder_core dut (
    .clk       (clk),
    .rst       (rst),
    .number_ch (num_ch),
    .char_ch   (chr_ch)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #8000000;
    $display("Test completed with failures");
    $finish;
  end

  always @(negedge clk) begin
    chr_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && chr_ch.valid && chr_ch.ready)
      board.check_char(chr_ch.char_code, chr_ch.last_char, chr_ch.range_error);
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_number(input logic [NumW-1:0] n);
    while ($urandom_range(99) < idle_pct) begin
      num_ch.valid     <= 1'b0;
      num_ch.number_in <= NumW'($urandom);
      @(negedge clk);
    end
    num_ch.valid     <= 1'b1;
    num_ch.number_in <= n;
    @(posedge clk);
    while (!num_ch.ready) @(posedge clk);
    board.note_number(n);
    @(negedge clk);
  endtask

  task automatic wait_drain();
    num_ch.valid <= 1'b0;
    @(negedge clk);
    while (board.pending() > 0) @(negedge clk);
  endtask

  function automatic logic [NumW-1:0] pick_number();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 6)  return NumW'($urandom_range(4000, 4095));
    if (r < 9)  return '0;
    if (r < 25) return NumW'($urandom_range(1, 99));
    if (r < 35) return NumW'($urandom_range(3000, 3999));
    return NumW'($urandom_range(0, 4095));
  endfunction

  logic [NumW-1:0] directed [22] = '{
    12'd0, 12'd1, 12'd4, 12'd5, 12'd9, 12'd10, 12'd40, 12'd50, 12'd90, 12'd100,
    12'd400, 12'd500, 12'd900, 12'd1000, 12'd1994, 12'd3888, 12'd3999, 12'd4000,
    12'd4095, 12'd2730, 12'd1365, 12'd3
  };

  int unsigned phase_idle  [4] = '{0, 56, 0, 12};
  int unsigned phase_stall [4] = '{0, 0, 56, 12};

  initial begin
    board            = new();
    rst              = 1'b1;
    idle_pct         = 0;
    stall_pct        = 0;
    num_ch.valid     = 1'b0;
    num_ch.number_in = '0;
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed[i]) send_number(directed[i]);
    wait_drain();

    for (int p = 0; p < 4; p++) begin
      idle_pct  = phase_idle[p];
      stall_pct = phase_stall[p];
      for (int i = 0; i < 80; i++) begin
        if (i == 40) wait_drain();
        send_number(pick_number());
      end
    end

    num_ch.valid <= 1'b0;
    @(negedge clk);
    while (board.pending() > 0) @(negedge clk);
    repeat (40) @(negedge clk);

    if (board.pending() > 0)
      board.report($sformatf("%0d beats never arrived", board.pending()));
    if (board.mismatches == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/rne_pkg.sv
hdl/rne_if.sv
hdl/rne_sequencer.sv
hdl/roman_numeral_encoder_core.sv
hdl/rne_checker.sv
tb/roman_numeral_encoder_core_tb.sv
